FILE: rtl/core/three_phase_sine_generator_assert.svh
`ifndef THREE_PHASE_SINE_GENERATOR_ASSERT_SVH
`define THREE_PHASE_SINE_GENERATOR_ASSERT_SVH

// Invariant checked at every edge outside reset.
`define TPSG_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Same-cycle implication checked at every edge outside reset.
`define TPSG_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/tpsg_pkg.sv
`timescale 1ns / 1ps

package tpsg_pkg;

   // default sizing
   localparam int TPSG_PHASE_BITS      = 32;
   localparam int TPSG_TABLE_ADDR_BITS = 10;
   localparam int TPSG_SAMPLE_BITS     = 16;

   // Q30 constants for the sine series
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   // number of Horner divide steps (theta^11 down to theta^3)
   localparam int HORNER_STEPS = 5;

   // Horner step k divides n (n < 2^32) by d = 2^a * o, o odd, innermost first.
   // floor(n / d) = ((n >> a) * m) >> sh with m = ceil(2^sh / o),
   // sh = 31 + ceil(log2 o); m fits 32 bits and the result is exact.
   function automatic logic [1:0] horner_pre_shift(input logic [2:0] step);
      logic [1:0] a;
      case (step)
         3'd0:    a = 2'd1;   // 110 = 2 * 55
         3'd1:    a = 2'd3;   // 72 = 8 * 9
         3'd2:    a = 2'd1;   // 42 = 2 * 21
         3'd3:    a = 2'd2;   // 20 = 4 * 5
         default: a = 2'd1;   // 6 = 2 * 3
      endcase
      return a;
   endfunction

   function automatic logic [31:0] horner_recip(input logic [2:0] step);
      logic [31:0] m;
      case (step)
         3'd0:    m = 32'd2498890064;   // ceil(2^37 / 55)
         3'd1:    m = 32'd3817748708;   // ceil(2^35 / 9)
         3'd2:    m = 32'd3272356036;   // ceil(2^36 / 21)
         3'd3:    m = 32'd3435973837;   // ceil(2^34 / 5)
         default: m = 32'd2863311531;   // ceil(2^33 / 3)
      endcase
      return m;
   endfunction

   function automatic logic [5:0] horner_post_shift(input logic [2:0] step);
      logic [5:0] sh;
      case (step)
         3'd0:    sh = 6'd37;
         3'd1:    sh = 6'd35;
         3'd2:    sh = 6'd36;
         3'd3:    sh = 6'd34;
         default: sh = 6'd33;
      endcase
      return sh;
   endfunction

endpackage

FILE: rtl/core/tpsg_table_fill.sv
`timescale 1ns / 1ps

// Builds the quarter-wave sine table after reset, one entry at a time.
// One shared 32x32 multiplier; the Horner divides by constants are reciprocal
// multiplies on it.
module tpsg_table_fill import tpsg_pkg::*; #(
   parameter int TABLE_ADDR_BITS = TPSG_TABLE_ADDR_BITS,
   parameter int SAMPLE_BITS     = TPSG_SAMPLE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       wr_en,
   output logic [TABLE_ADDR_BITS-2:0] wr_addr,
   output logic [SAMPLE_BITS-2:0]     wr_data,
   output logic                       fill_done
);

   localparam int QBITS = TABLE_ADDR_BITS - 2;
   localparam int XW    = TABLE_ADDR_BITS - 1;
   localparam logic [XW-1:0]          QUARTER = XW'(1) << QBITS;
   localparam logic [SAMPLE_BITS-2:0] FULL    = '1;

   typedef enum logic [3:0] {
      FILL_TH,
      FILL_T2,
      FILL_DIV_LD,
      FILL_DIV_WB,
      FILL_PM,
      FILL_S,
      FILL_MAG,
      FILL_WR,
      FILL_DONE
   } fill_state_type;

   fill_state_type state_ff;
   logic [XW-1:0]  x_ff;
   logic [30:0]    th_ff;
   logic [31:0]    t2_ff;
   logic [30:0]    p_ff;
   logic [63:0]    prod_ff;
   logic [2:0]     k_ff;

   logic [31:0] prod_hi;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [30:0] u_val;
   logic [31:0] div_num;
   logic [63:0] quo_full;
   logic [63:0] mag_sum;
   logic [33:0] mag_wide;
   logic [SAMPLE_BITS-2:0] mag;

   assign prod_hi = prod_ff[61:30];
   assign u_val   = 31'(x_ff) << (30 - QBITS);

   // divide by constant: pre-shift, multiply by reciprocal, post-shift
   assign div_num  = prod_hi >> horner_pre_shift(k_ff);
   assign quo_full = prod_ff >> horner_post_shift(k_ff);

   // round to FULL scale, clamp
   assign mag_sum  = prod_ff + 64'(ONE_Q30 >> 1);
   assign mag_wide = mag_sum[63:30];
   assign mag      = (mag_wide > 34'(FULL)) ? FULL : mag_wide[SAMPLE_BITS-2:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         FILL_TH: begin
            mul_a = 32'(u_val);
            mul_b = HALF_PI_Q30;
         end
         FILL_T2: begin
            mul_a = prod_hi;
            mul_b = prod_hi;
         end
         FILL_DIV_LD: begin
            mul_a = div_num;
            mul_b = horner_recip(k_ff);
         end
         FILL_PM: begin
            mul_a = t2_ff;
            mul_b = {1'b0, p_ff};
         end
         FILL_S: begin
            mul_a = {1'b0, th_ff};
            mul_b = {1'b0, p_ff};
         end
         FILL_MAG: begin
            mul_a = prod_hi;
            mul_b = 32'(FULL);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign wr_en     = (state_ff == FILL_WR);
   assign wr_addr   = x_ff;
   assign wr_data   = mag;
   assign fill_done = (state_ff == FILL_DONE);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         state_ff <= FILL_TH;
         x_ff     <= '0;
      end else begin
         case (state_ff)
            FILL_TH: begin
               state_ff <= FILL_T2;
            end
            FILL_T2: begin
               th_ff    <= prod_hi[30:0];
               k_ff     <= '0;
               state_ff <= FILL_DIV_LD;
            end
            FILL_DIV_LD: begin
               // first step divides t2 itself
               if (k_ff == '0) begin
                  t2_ff <= prod_hi;
               end
               state_ff <= FILL_DIV_WB;
            end
            FILL_DIV_WB: begin
               p_ff <= ONE_Q30 - quo_full[30:0];
               if (k_ff == 3'(HORNER_STEPS - 1)) begin
                  state_ff <= FILL_S;
               end else begin
                  k_ff     <= k_ff + 3'd1;
                  state_ff <= FILL_PM;
               end
            end
            FILL_PM: begin
               state_ff <= FILL_DIV_LD;
            end
            FILL_S: begin
               state_ff <= FILL_MAG;
            end
            FILL_MAG: begin
               state_ff <= FILL_WR;
            end
            FILL_WR: begin
               if (x_ff == QUARTER) begin
                  state_ff <= FILL_DONE;
               end else begin
                  x_ff     <= x_ff + XW'(1);
                  state_ff <= FILL_TH;
               end
            end
            FILL_DONE: begin
               state_ff <= FILL_DONE;
            end
            default: begin
               state_ff <= FILL_TH;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/three_phase_sine_generator.sv
// three_phase_sine_generator: an accepted request passes the table-read and product registers
// into the result queue, which drives rsp_*; one request per cycle sustained while rsp_tready
// drains the queue, with three table reads per cycle (two read ports on one table copy, one on
// the other). Reset (synchronous, active high) clears the registers and held outputs, resets
// the phase, then rebuilds the sine table (2^(TABLE_ADDR_BITS-2) + 1 entries) with req_tready low.
`timescale 1ns / 1ps
`include "three_phase_sine_generator_assert.svh"

module three_phase_sine_generator import tpsg_pkg::*; #(
   parameter int PHASE_BITS      = TPSG_PHASE_BITS,
   parameter int TABLE_ADDR_BITS = TPSG_TABLE_ADDR_BITS,
   parameter int SAMPLE_BITS     = TPSG_SAMPLE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] period_elapsed
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] phase_u, [31:16] phase_v, [47:32] phase_w
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Sizing
   // ---------------------------------------------------------------------------------
   localparam int QBITS       = TABLE_ADDR_BITS - 2;
   localparam int XW          = TABLE_ADDR_BITS - 1;           // quarter-table address
   localparam int TABLE_DEPTH = (1 << QBITS) + 1;              // entries 0..Q inclusive
   localparam int PROD_W      = 16 + SAMPLE_BITS;
   localparam int RES_W       = PROD_W + 1 - (SAMPLE_BITS - 1);
   localparam int STEP_SHIFT  = 48 - PHASE_BITS;
   localparam logic [XW-1:0] QUARTER = XW'(1) << QBITS;

   // 120 degrees as a fraction of the turn, floor((2^PHASE_BITS + 1) / 3)
   localparam logic [PHASE_BITS-1:0] TURN_THIRD =
      PHASE_BITS'(((65'd1 << PHASE_BITS) + 65'd1) / 65'd3);

   // result queue: covers the three pipeline stages plus slack; req_tready drops once it is full
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int PTR_W      = FIFO_AW + 1;

   // register map
   localparam logic [1:0] CSR_ACTIVE     = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [1:0] CSR_AMPLITUDE  = 2'd2;

   typedef enum logic [1:0] {
      ITEM_CLEAR,    // block inactive: zero out
      ITEM_HOLD,     // no period elapsed: repeat last
      ITEM_UPDATE    // advance phase, new samples
   } item_kind_type;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic                    active_ff;
   logic [31:0]             phase_step_ff;
   logic signed [15:0]      amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         phase_step_ff <= '0;
         amplitude_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE:     active_ff     <= csr_wdata[0];
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Sine table build and storage. Two copies of the same quarter wave: copy A
   // serves phases u and v, copy B serves w.
   // ---------------------------------------------------------------------------------
   logic                    tbl_wr_en;
   logic [XW-1:0]           tbl_wr_addr;
   logic [SAMPLE_BITS-2:0]  tbl_wr_data;
   logic                    fill_done;

   tpsg_table_fill #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_fill (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (tbl_wr_en),
      .wr_addr   (tbl_wr_addr),
      .wr_data   (tbl_wr_data),
      .fill_done (fill_done)
   );

   logic [SAMPLE_BITS-2:0] table_a [TABLE_DEPTH];
   logic [SAMPLE_BITS-2:0] table_b [TABLE_DEPTH];

   // ---------------------------------------------------------------------------------
   // Request accept and flow control. inflight_ff counts requests accepted and not yet
   // popped from the result queue, so the queue can never overflow.
   // ---------------------------------------------------------------------------------
   logic                    req_acc;
   logic                    rsp_pop;
   logic [PTR_W-1:0]        inflight_ff;
   logic [PTR_W-1:0]        inflight_in;
   item_kind_type           kind_in;

   assign req_acc    = req_tvalid & req_tready;
   assign req_tready = fill_done && (inflight_ff < PTR_W'(FIFO_DEPTH));
   assign rsp_pop    = rsp_tvalid & rsp_tready;
   assign inflight_in = inflight_ff + PTR_W'(req_acc) - PTR_W'(rsp_pop);

   always_comb begin
      if (!active_ff) begin
         kind_in = ITEM_CLEAR;
      end else if (req_tdata[0]) begin
         kind_in = ITEM_UPDATE;
      end else begin
         kind_in = ITEM_HOLD;
      end
   end

   // ---------------------------------------------------------------------------------
   // Phase accumulators. v and w ride at +/-120 degrees from u, so each lane
   // needs only its own add.
   // ---------------------------------------------------------------------------------
   logic [47:0]             step_wide;
   logic [PHASE_BITS-1:0]   step_aligned;
   logic [PHASE_BITS-1:0]   acc_u_ff, acc_v_ff, acc_w_ff;
   logic [PHASE_BITS-1:0]   acc_u_in, acc_v_in, acc_w_in;
   logic                    advance;

   // step << (PHASE_BITS-32) for wide phase, truncated >> (32-PHASE_BITS) for narrow
   assign step_wide    = {phase_step_ff, 16'd0};
   assign step_aligned = PHASE_BITS'(step_wide >> STEP_SHIFT);
   assign advance      = req_acc && (kind_in == ITEM_UPDATE);

   assign acc_u_in = advance ? acc_u_ff + step_aligned : acc_u_ff;
   assign acc_v_in = advance ? acc_v_ff + step_aligned : acc_v_ff;
   assign acc_w_in = advance ? acc_w_ff + step_aligned : acc_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_u_ff    <= '0;
         acc_v_ff    <= TURN_THIRD;
         acc_w_ff    <= '0 - TURN_THIRD;
         inflight_ff <= '0;
      end else begin
         acc_u_ff    <= acc_u_in;
         acc_v_ff    <= acc_v_in;
         acc_w_ff    <= acc_w_in;
         inflight_ff <= inflight_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: quarter-wave addressing off the freshly updated accumulators.
   // Odd quadrants mirror to Q - r; the top index bit gives the sign.
   // ---------------------------------------------------------------------------------
   function automatic logic [XW-1:0] quarter_addr(input logic [TABLE_ADDR_BITS-1:0] idx);
      logic [QBITS-1:0] r;
      r = idx[QBITS-1:0];
      return idx[QBITS] ? QUARTER - XW'(r) : XW'(r);
   endfunction

   logic                    v1_ff;
   item_kind_type           kind1_ff;
   logic [XW-1:0]           addr_u, addr_v, addr_w;

   assign addr_u = quarter_addr(acc_u_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
   assign addr_v = quarter_addr(acc_v_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
   assign addr_w = quarter_addr(acc_w_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS]);

   // ---------------------------------------------------------------------------------
   // Stage 2: registered table reads, sign, scale by amplitude
   // ---------------------------------------------------------------------------------
   logic                    v2_ff;
   item_kind_type           kind2_ff;
   logic [SAMPLE_BITS-2:0]  rd_u_ff, rd_v_ff, rd_w_ff;
   logic [2:0]              neg2_ff;          // [0] u, [1] v, [2] w

   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         table_a[tbl_wr_addr] <= tbl_wr_data;
         table_b[tbl_wr_addr] <= tbl_wr_data;
      end
      rd_u_ff <= table_a[addr_u];
      rd_v_ff <= table_a[addr_v];
      rd_w_ff <= table_b[addr_w];
      neg2_ff <= {acc_w_ff[PHASE_BITS-1], acc_v_ff[PHASE_BITS-1], acc_u_ff[PHASE_BITS-1]};
   end

   function automatic logic signed [SAMPLE_BITS-1:0] signed_sample(
      input logic [SAMPLE_BITS-2:0] mag,
      input logic                   neg
   );
      logic signed [SAMPLE_BITS-1:0] s;
      s = {1'b0, mag};
      return neg ? -s : s;
   endfunction

   logic signed [PROD_W-1:0] prod_u, prod_v, prod_w;

   assign prod_u = amplitude_ff * signed_sample(rd_u_ff, neg2_ff[0]);
   assign prod_v = amplitude_ff * signed_sample(rd_v_ff, neg2_ff[1]);
   assign prod_w = amplitude_ff * signed_sample(rd_w_ff, neg2_ff[2]);

   // ---------------------------------------------------------------------------------
   // Stage 3: round half up, saturate to 16 bits, hold/clear, queue the result
   // ---------------------------------------------------------------------------------
   logic                    v3_ff;
   item_kind_type           kind3_ff;
   logic signed [PROD_W-1:0] prod_u_ff, prod_v_ff, prod_w_ff;

   function automatic logic [15:0] round_sat(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W:0]  biased;
      logic signed [PROD_W:0]  shifted;
      logic [RES_W-1:0]        res;
      logic [RES_W-16:0]       hi;
      biased  = $signed({prod[PROD_W-1], prod} + (PROD_W+1)'(1 << (SAMPLE_BITS - 2)));
      shifted = biased >>> (SAMPLE_BITS - 1);
      res     = shifted[RES_W-1:0];
      hi      = res[RES_W-1:15];
      if ((&hi) || !(|hi)) begin
         return res[15:0];
      end
      return res[RES_W-1] ? 16'h8000 : 16'h7FFF;
   endfunction

   logic [15:0]             held_u_ff, held_v_ff, held_w_ff;
   logic [15:0]             res_u, res_v, res_w;

   always_comb begin
      case (kind3_ff)
         ITEM_UPDATE: begin
            res_u = round_sat(prod_u_ff);
            res_v = round_sat(prod_v_ff);
            res_w = round_sat(prod_w_ff);
         end
         ITEM_HOLD: begin
            res_u = held_u_ff;
            res_v = held_v_ff;
            res_w = held_w_ff;
         end
         default: begin
            res_u = '0;
            res_v = '0;
            res_w = '0;
         end
      endcase
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      kind1_ff  <= kind_in;
      kind2_ff  <= kind1_ff;
      kind3_ff  <= kind2_ff;
      prod_u_ff <= prod_u;
      prod_v_ff <= prod_v;
      prod_w_ff <= prod_w;
   end

   // pipeline valids and held outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         held_u_ff <= '0;
         held_v_ff <= '0;
         held_w_ff <= '0;
      end else begin
         v1_ff <= req_acc;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff) begin
            held_u_ff <= res_u;
            held_v_ff <= res_v;
            held_w_ff <= res_w;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result queue: decouples the pipeline from rsp_tready
   // ---------------------------------------------------------------------------------
   logic [47:0]             fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W-1:0]        q_count;

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         fifo_mem[wr_ptr_ff[FIFO_AW-1:0]] <= {res_w, res_v, res_u};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (v3_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   assign q_count    = wr_ptr_ff - rd_ptr_ff;
   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_tdata  = fifo_mem[rd_ptr_ff[FIFO_AW-1:0]];

   // ---------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------
   `TPSG_ASSERT_ALWAYS(a_offset_v, acc_v_ff == acc_u_ff + TURN_THIRD, "v lane lost its offset")
   `TPSG_ASSERT_ALWAYS(a_offset_w, acc_w_ff == acc_u_ff - TURN_THIRD, "w lane lost its offset")
   `TPSG_ASSERT_IMPLY(a_queue_room, v3_ff, q_count < PTR_W'(FIFO_DEPTH), "result queue overflow")
   `TPSG_ASSERT_ALWAYS(a_inflight, inflight_ff >= q_count, "queue holds more than was accepted")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // Register map of the write port
   typedef enum logic [1:0] {
      REG_ACTIVE    = 2'd0,
      REG_STEP      = 2'd1,
      REG_AMPLITUDE = 2'd2,
      REG_SPARE     = 2'd3   // unmapped, writes must be ignored
   } reg_index_type;

   typedef enum logic {
      ROW_REQ = 1'b0,   // one scheduler pass, data[0] = period_elapsed
      ROW_CSR = 1'b1    // register write, issued only when the block is idle
   } row_kind_type;

   // One result: the three phase outputs
   typedef struct packed {
      logic signed [15:0] u;
      logic signed [15:0] v;
      logic signed [15:0] w;
   } tri_out_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type idx;
      logic [31:0]   data;
      bit            typed;   // 1: compare with want, 0: use the predictor
      tri_out_type   want;
   } row_type;

   localparam tri_out_type ZERO_OUT = '0;

   localparam int PLAN_ROWS      = 28;
   localparam int RANDOM_ITEMS   = 600;
   localparam int MAX_GAP        = 16;
   localparam int IDLE_TAIL      = 6;        // idle margin after the last result
   localparam int HOLD_CYCLES    = 300;      // long receiver hold-off
   // Reset rebuilds the sine table with no traffic at all;
   // the limit covers that several times over.
   localparam int QUIET_LIMIT    = 25000;

   localparam logic [31:0] THIRD_TURN = 32'd1431655765;   // floor((2^32 + 1) / 3)
   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
   localparam logic [63:0] Q30_HALFPI = 64'd1686629713;
   localparam logic [63:0] FULL_SCALE = 64'd32767;

   // Directed part: reset state, inactive behavior, quarter-turn steps that land
   // on the table's quadrant edges, wrap in both directions, amplitude extremes,
   // masked upper bits, the unmapped register and a zero step.
   localparam row_type PLAN [PLAN_ROWS] = '{
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0000, 1'b1, ZERO_OUT},  // right after reset
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b1, ZERO_OUT},  // inactive ignores tick
      '{ROW_CSR, REG_STEP,      32'h4000_0000, 1'b0, ZERO_OUT},  // quarter turn
      '{ROW_CSR, REG_AMPLITUDE, 32'h0000_7FFF, 1'b0, ZERO_OUT},  // max positive
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b1, ZERO_OUT},  // still inactive
      '{ROW_CSR, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0000, 1'b1, ZERO_OUT},  // holds reset zeros
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},  // peak of u
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},  // half turn
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0000, 1'b0, ZERO_OUT},  // hold
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},  // trough of u
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},  // wraps to zero
      '{ROW_CSR, REG_AMPLITUDE, 32'hABCD_8000, 1'b0, ZERO_OUT},  // max negative, junk above
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},
      '{ROW_CSR, REG_STEP,      32'hFFFF_FFFF, 1'b0, ZERO_OUT},  // one LSB backward
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0000, 1'b0, ZERO_OUT},
      '{ROW_CSR, REG_AMPLITUDE, 32'h0000_0000, 1'b0, ZERO_OUT},
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b1, ZERO_OUT},  // zero amplitude
      '{ROW_CSR, REG_SPARE,     32'hFFFF_FFFF, 1'b0, ZERO_OUT},  // must change nothing
      '{ROW_CSR, REG_ACTIVE,    32'hFFFF_FFFE, 1'b0, ZERO_OUT},  // bit 0 clear -> off
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b1, ZERO_OUT},  // off clears outputs
      '{ROW_CSR, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},
      '{ROW_CSR, REG_STEP,      32'h0000_0000, 1'b0, ZERO_OUT},
      '{ROW_CSR, REG_AMPLITUDE, 32'h0000_C000, 1'b0, ZERO_OUT},
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT},  // phase stays put
      '{ROW_REQ, REG_ACTIVE,    32'h0000_0001, 1'b0, ZERO_OUT}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] period_elapsed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [15:0] phase_u, [31:16] phase_v, [47:32] phase_w
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   three_phase_sine_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: our own copy of the registers, the phase and held outputs
   logic               gen_active = 1'b0;
   logic [31:0]        gen_step   = '0;
   logic signed [15:0] gen_amp    = '0;
   logic [31:0]        gen_phase  = '0;
   tri_out_type        gen_out    = '0;

   tri_out_type expected_outputs[$];   // oldest at the front

   int  mismatches    = 0;
   int  requests_sent = 0;
   int  results_seen  = 0;
   int  csr_writes    = 0;
   int  settings_run  = 0;
   int  quiet_cycles  = 0;
   bit  sender_burst  = 1'b0;
   bit  hold_off_req  = 1'b0;   // asks the receiver for one long stall

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Quarter-wave sine of a 32-bit phase, Q30 Horner series with truncation,
   // scaled to 15 bits with round half up.
   function automatic int sine_q15(input logic [31:0] ph);
      logic [9:0]  idx;
      logic [1:0]  quad;
      logic [7:0]  r;
      logic [8:0]  x;
      logic [63:0] arg, th, t2, p, s, mag;
      idx  = ph[31:22];
      quad = idx[9:8];
      r    = idx[7:0];
      x    = quad[0] ? 9'd256 - {1'b0, r} : {1'b0, r};   // mirror in odd quadrants
      arg  = 64'(x) << 22;
      th   = (arg * Q30_HALFPI) >> 30;
      t2   = (th * th) >> 30;
      p    = Q30_ONE - t2 / 64'd110;
      p    = Q30_ONE - ((t2 * p) >> 30) / 64'd72;
      p    = Q30_ONE - ((t2 * p) >> 30) / 64'd42;
      p    = Q30_ONE - ((t2 * p) >> 30) / 64'd20;
      p    = Q30_ONE - ((t2 * p) >> 30) / 64'd6;
      s    = (th * p) >> 30;
      mag  = (s * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
      if (mag > FULL_SCALE)
         mag = FULL_SCALE;
      return quad[1] ? -int'(mag) : int'(mag);
   endfunction

   // amplitude * sample / 2^15, ties toward +inf, saturated to 16 bits
   function automatic logic signed [15:0] scale_amp(input int sample);
      longint prod;
      prod = longint'(gen_amp) * longint'(sample);
      prod = (prod + 64'sd16384) >>> 15;
      if (prod > 32767)
         prod = 32767;
      else if (prod < -32768)
         prod = -32768;
      return 16'(prod);
   endfunction

   // One scheduler pass through the predictor
   function automatic void advance_generator(input logic tick);
      if (!gen_active) begin
         gen_out = '0;
      end else if (tick) begin
         gen_phase = gen_phase + gen_step;
         gen_out.u = scale_amp(sine_q15(gen_phase));
         gen_out.v = scale_amp(sine_q15(gen_phase + THIRD_TURN));
         gen_out.w = scale_amp(sine_q15(gen_phase - THIRD_TURN));
      end
   endfunction

   function automatic void apply_register(input reg_index_type idx, input logic [31:0] data);
      case (idx)
         REG_ACTIVE:    gen_active = data[0];
         REG_STEP:      gen_step   = data;
         REG_AMPLITUDE: gen_amp    = data[15:0];
         default:       ;
      endcase
   endfunction

   // Offer one request after a random gap; predict its result once accepted.
   task automatic offer(input logic tick, input bit typed, input tri_out_type want);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, tick};
      do @(posedge clock); while (!req_tready);
      advance_generator(tick);
      expected_outputs.push_back(typed ? want : gen_out);
      requests_sent++;
   endtask

   // Drain the pipeline before touching any register.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   // Random register setting for the next stretch; extremes weighted in.
   task automatic new_setting();
      logic [31:0] data;
      wait_idle();
      if ($urandom_range(0, 3) != 0) begin
         data    = $urandom();
         data[0] = ($urandom_range(0, 19) < 17);   // mostly running
         csr_write(REG_ACTIVE, data);
      end
      if ($urandom_range(0, 1) != 0) begin
         case ($urandom_range(0, 4))
            0:       data = 32'h0000_0000;
            1:       data = 32'hFFFF_FFFF;
            2:       data = 32'h8000_0000;
            3:       data = $urandom_range(0, 32'h00FF_FFFF);   // slow sweep
            default: data = $urandom();
         endcase
         csr_write(REG_STEP, data);
      end
      if ($urandom_range(0, 1) != 0) begin
         data = $urandom();                              // upper half is junk
         case ($urandom_range(0, 4))
            0:       data[15:0] = 16'h7FFF;
            1:       data[15:0] = 16'h8000;
            2:       data[15:0] = 16'h0000;
            default: ;
         endcase
         csr_write(REG_AMPLITUDE, data);
      end
      if ($urandom_range(0, 9) == 0)
         csr_write(REG_SPARE, $urandom());
      settings_run++;
   endtask

   // Stimulus: directed rows, then random stretches between register changes
   initial begin : stimulus
      int n;
      int bias;
      int target;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= REG_ACTIVE;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(PLAN[i].idx, PLAN[i].data);
         end else begin
            offer(PLAN[i].data[0], PLAN[i].typed, PLAN[i].want);
         end
      end

      target = requests_sent + RANDOM_ITEMS;
      while (requests_sent < target) begin
         new_setting();
         n            = $urandom_range(10, 60);
         bias         = $urandom_range(1, 9);
         sender_burst = ($urandom_range(0, 3) == 0);
         // third stretch: back-to-back requests against a stalled receiver
         if (settings_run == 3) begin
            hold_off_req = 1'b1;
            sender_burst = 1'b1;
            n            = 80;
         end
         repeat (n)
            offer($urandom_range(0, 9) < bias, 1'b0, ZERO_OUT);
      end
      sender_burst = 1'b0;

      wait_idle();
      $display("Covered %0d requests, %0d results, %0d register writes over %0d settings,",
               requests_sent, results_seen, csr_writes, settings_run);
      $display("with random gaps and stalls on both sides and one long receiver hold-off.");
      if (mismatches == 0 && expected_outputs.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random stall before each result, runs of no stall, one long hold
   initial begin : receiver
      int stall;
      int burst_left;
      burst_left = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 19) == 0)
               burst_left = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Result checker: each accepted result against the oldest prediction
   always @(posedge clock) begin
      tri_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_outputs.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_tdata[15:0] !== want.u) begin
               $error("phase_u: expected %0d, actual %0d", want.u, $signed(rsp_tdata[15:0]));
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.v) begin
               $error("phase_v: expected %0d, actual %0d", want.v, $signed(rsp_tdata[31:16]));
               mismatches++;
            end
            if (rsp_tdata[47:32] !== want.w) begin
               $error("phase_w: expected %0d, actual %0d", want.w, $signed(rsp_tdata[47:32]));
               mismatches++;
            end
         end
      end
   end

   // Watchdog: too long without any request, result or register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, expected_outputs.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

FILE: three_phase_sine_generator.f
+incdir+rtl/core
rtl/core/tpsg_pkg.sv
rtl/core/tpsg_table_fill.sv
rtl/core/three_phase_sine_generator.sv
tb/tb.sv
